// File: hdl/tmt_pkg.sv
// Shared types and constants for the text-mode terminal.
// Used by every module of the block but tmt_ram; depends on nothing.
package tmt_pkg;

   localparam int MODE_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int COL_W     = 5;
   localparam int ROW_W     = 5;
   localparam int ADDR_W    = 10;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [MODE_W-1:0] MODE_PUT    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF     = 8'd10;
   localparam logic [CHAR_W-1:0] REVERSE_BIT = 8'h80;

   localparam logic [REG_IDX_W-1:0] REG_CODE_CLEAR       = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_CODE_HOME        = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CODE_REVERSE_OFF = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_CODE_REVERSE_ON  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_CODE_BACKSPACE   = 3'd4;

   localparam logic [CHAR_W-1:0] RST_CODE_CLEAR       = 8'd12;
   localparam logic [CHAR_W-1:0] RST_CODE_HOME        = 8'd19;
   localparam logic [CHAR_W-1:0] RST_CODE_REVERSE_OFF = 8'd15;
   localparam logic [CHAR_W-1:0] RST_CODE_REVERSE_ON  = 8'd14;
   localparam logic [CHAR_W-1:0] RST_CODE_BACKSPACE   = 8'd8;

   typedef struct packed {
      logic [CHAR_W-1:0] code_clear;
      logic [CHAR_W-1:0] code_home;
      logic [CHAR_W-1:0] code_reverse_off;
      logic [CHAR_W-1:0] code_reverse_on;
      logic [CHAR_W-1:0] code_backspace;
   } cfg_type;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_col;
      logic [ROW_W-1:0]  cursor_row;
      logic              reverse_on;
      logic              wrote_cell;
      logic [ADDR_W-1:0] cell_addr;
      logic [CHAR_W-1:0] cell_value;
      logic              scrolled;
      logic              cleared;
      logic [CHAR_W-1:0] read_value;
   } rsp_type;

endpackage

// File: hdl/tmt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 768,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/tmt_csr.sv
// Configuration registers of the terminal behind an APB-style write/read port.
// Depends on tmt_pkg for register indexes, reset codes and cfg_type.
module tmt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tmt_pkg::CSR_AW-1:0]  paddr,
   input  logic [tmt_pkg::CSR_DW-1:0]  pwdata,
   output logic [tmt_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output tmt_pkg::cfg_type            cfg
);

   tmt_pkg::cfg_type                 cfg_ff, cfg_in;
   logic [tmt_pkg::REG_IDX_W-1:0]    idx;
   logic                             wr_en;
   logic [tmt_pkg::CHAR_W-1:0]       rd_byte;

   assign idx    = paddr[tmt_pkg::CSR_AW-1:2];
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            tmt_pkg::REG_CODE_CLEAR:       cfg_in.code_clear       = pwdata[7:0];
            tmt_pkg::REG_CODE_HOME:        cfg_in.code_home        = pwdata[7:0];
            tmt_pkg::REG_CODE_REVERSE_OFF: cfg_in.code_reverse_off = pwdata[7:0];
            tmt_pkg::REG_CODE_REVERSE_ON:  cfg_in.code_reverse_on  = pwdata[7:0];
            tmt_pkg::REG_CODE_BACKSPACE:   cfg_in.code_backspace   = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         tmt_pkg::REG_CODE_CLEAR:       rd_byte = cfg_ff.code_clear;
         tmt_pkg::REG_CODE_HOME:        rd_byte = cfg_ff.code_home;
         tmt_pkg::REG_CODE_REVERSE_OFF: rd_byte = cfg_ff.code_reverse_off;
         tmt_pkg::REG_CODE_REVERSE_ON:  rd_byte = cfg_ff.code_reverse_on;
         tmt_pkg::REG_CODE_BACKSPACE:   rd_byte = cfg_ff.code_backspace;
         default:                       rd_byte = '0;
      endcase
   end

   assign prdata = tmt_pkg::CSR_DW'(rd_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_clear       <= tmt_pkg::RST_CODE_CLEAR;
         cfg_ff.code_home        <= tmt_pkg::RST_CODE_HOME;
         cfg_ff.code_reverse_off <= tmt_pkg::RST_CODE_REVERSE_OFF;
         cfg_ff.code_reverse_on  <= tmt_pkg::RST_CODE_REVERSE_ON;
         cfg_ff.code_backspace   <= tmt_pkg::RST_CODE_BACKSPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/tmt_seq.sv
// Item decoder and screen-store sequencer: cursor, reverse flag, clear and scroll sweeps.
// Depends on tmt_pkg; drives the ports of one tmt_ram instance.
module tmt_seq #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 24,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int AW     = $clog2(CELLS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tmt_pkg::cfg_type             cfg,
   input  logic                         req_valid,
   input  logic [tmt_pkg::MODE_W-1:0]   req_mode,
   input  logic [tmt_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tmt_pkg::COL_W-1:0]    req_col,
   input  logic [tmt_pkg::ROW_W-1:0]    req_row,
   output logic                         req_stall,
   input  logic                         slot_free,
   output logic                         res_load,
   output tmt_pkg::rsp_type             res,
   output logic                         mem_we,
   output logic [AW-1:0]                mem_waddr,
   output logic [tmt_pkg::CHAR_W-1:0]   mem_wdata,
   output logic [AW-1:0]                mem_raddr,
   input  logic [tmt_pkg::CHAR_W-1:0]   mem_rdata
);

   localparam int CW = $clog2(COLUMNS);
   localparam int RW = $clog2(ROWS);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_READ   = 4'b0010,
      S_SCROLL = 4'b0100,
      S_FILL   = 4'b1000
   } seq_state_type;

   seq_state_type state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic          rev_ff, rev_in;
   logic          cp_vld_ff, cp_vld_in;
   logic [AW-1:0] cp_addr_ff, cp_addr_in;

   logic                        accept;
   logic [tmt_pkg::CHAR_W-1:0]  c;
   logic [CW-1:0]               clamp_col;
   logic [RW-1:0]               clamp_row;
   logic [AW-1:0]               rd_idx;
   logic [AW-1:0]               cur_idx;
   logic                        last_col;
   logic                        last_row;
   logic                        wrote, scrolled, cleared;
   logic [tmt_pkg::ADDR_W-1:0]  cell_addr;
   logic [tmt_pkg::CHAR_W-1:0]  cell_val;
   logic [tmt_pkg::CHAR_W-1:0]  read_val;

   assign c         = req_char_code;
   assign accept    = req_valid && (state_ff == S_IDLE) && slot_free;
   assign req_stall = !((state_ff == S_IDLE) && slot_free);

   assign clamp_col = (8'(req_col) > 8'(COLUMNS - 1)) ? CW'(COLUMNS - 1) : CW'(req_col);
   assign clamp_row = (8'(req_row) > 8'(ROWS - 1)) ? RW'(ROWS - 1) : RW'(req_row);
   assign rd_idx    = AW'(clamp_row) * AW'(COLUMNS) + AW'(clamp_col);
   assign cur_idx   = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign last_col  = col_ff >= CW'(COLUMNS - 1);
   assign last_row  = row_ff >= RW'(ROWS - 1);

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      rev_in     = rev_ff;
      cp_vld_in  = 1'b0;
      cp_addr_in = cnt_ff;
      mem_we     = 1'b0;
      mem_waddr  = cnt_ff;
      mem_wdata  = tmt_pkg::CHAR_SPACE;
      mem_raddr  = rd_idx;
      res_load   = 1'b0;
      wrote      = 1'b0;
      scrolled   = 1'b0;
      cleared    = 1'b0;
      cell_addr  = '0;
      cell_val   = '0;
      read_val   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_load = 1'b1;
               case (req_mode)
                  tmt_pkg::MODE_PUT: begin
                     if (c == cfg.code_clear) begin
                        col_in   = '0;
                        row_in   = '0;
                        cleared  = 1'b1;
                        cnt_in   = '0;
                        state_in = S_FILL;
                     end else if (c == cfg.code_home) begin
                        col_in = '0;
                        row_in = '0;
                     end else if (c == cfg.code_reverse_off) begin
                        rev_in = 1'b0;
                     end else if (c == cfg.code_reverse_on) begin
                        rev_in = 1'b1;
                     end else if (c == cfg.code_backspace) begin
                        if (col_ff != '0) begin
                           col_in = col_ff - CW'(1);
                        end else if (row_ff != '0) begin
                           row_in = row_ff - RW'(1);
                           col_in = CW'(COLUMNS - 1);
                        end
                     end else if ((c == tmt_pkg::CHAR_CR) || (c == tmt_pkg::CHAR_LF)) begin
                        col_in = '0;
                        if (last_row) begin
                           scrolled = 1'b1;
                        end else begin
                           row_in = row_ff + RW'(1);
                        end
                     end else begin
                        wrote     = 1'b1;
                        cell_val  = rev_ff ? (c | tmt_pkg::REVERSE_BIT) : c;
                        cell_addr = tmt_pkg::ADDR_W'(cur_idx);
                        mem_we    = 1'b1;
                        mem_waddr = cur_idx;
                        mem_wdata = cell_val;
                        if (last_col) begin
                           col_in = '0;
                           if (last_row) begin
                              scrolled = 1'b1;
                           end else begin
                              row_in = row_ff + RW'(1);
                           end
                        end else begin
                           col_in = col_ff + CW'(1);
                        end
                     end
                     if (scrolled) begin
                        cnt_in   = '0;
                        state_in = S_SCROLL;
                     end
                  end
                  tmt_pkg::MODE_LOCATE: begin
                     col_in = clamp_col;
                     row_in = clamp_row;
                  end
                  tmt_pkg::MODE_READ: begin
                     // hold the result until the cell comes back
                     res_load = 1'b0;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            res_load = 1'b1;
            read_val = mem_rdata;
            state_in = S_IDLE;
         end
         S_SCROLL: begin
            // read one row below, write back the cell fetched last cycle
            mem_raddr  = cnt_ff + AW'(COLUMNS);
            cp_vld_in  = 1'b1;
            cp_addr_in = cnt_ff;
            mem_we     = cp_vld_ff;
            mem_waddr  = cp_addr_ff;
            mem_wdata  = mem_rdata;
            if (cnt_ff == AW'(CELLS - COLUMNS - 1)) begin
               cnt_in   = AW'(CELLS - COLUMNS);
               state_in = S_FILL;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         S_FILL: begin
            mem_we = 1'b1;
            if (cp_vld_ff) begin
               // drain the last copy before blanking
               mem_waddr = cp_addr_ff;
               mem_wdata = mem_rdata;
            end else begin
               mem_waddr = cnt_ff;
               mem_wdata = tmt_pkg::CHAR_SPACE;
               if (cnt_ff == AW'(CELLS - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  cnt_in = cnt_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      res.cursor_col = tmt_pkg::COL_W'(col_in);
      res.cursor_row = tmt_pkg::ROW_W'(row_in);
      res.reverse_on = rev_in;
      res.wrote_cell = wrote;
      res.cell_addr  = cell_addr;
      res.cell_value = cell_val;
      res.scrolled   = scrolled;
      res.cleared    = cleared;
      res.read_value = read_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_FILL;
         cnt_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         rev_ff    <= 1'b0;
         cp_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         rev_ff    <= rev_in;
         cp_vld_ff <= cp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= cp_addr_in;
   end

   a_load_has_slot: assert property (@(posedge clock) disable iff (reset)
      res_load |-> slot_free)
      else $error("result loaded while the pending slot is full");

   a_idle_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && mem_we) |-> accept)
      else $error("screen store written in idle without a transaction");

   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= CW'(COLUMNS - 1)) && (row_ff <= RW'(ROWS - 1)))
      else $error("cursor left the screen");

   a_scroll_to_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL) |=> ((state_ff == S_SCROLL) || (state_ff == S_FILL)))
      else $error("scroll sweep ended without the blanking pass");

endmodule

// File: hdl/tmt_rsp.sv
// Result path: a pending slot followed by the output register of the result channel.
// Depends on tmt_pkg for rsp_type.
module tmt_rsp (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_load,
   input  tmt_pkg::rsp_type  res,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmt_pkg::rsp_type  rsp_data
);

   logic             pend_vld_ff, pend_vld_in;
   tmt_pkg::rsp_type pend_ff, pend_in;
   logic             out_vld_ff, out_vld_in;
   tmt_pkg::rsp_type out_ff, out_in;
   logic             move;

   assign move      = pend_vld_ff && (!out_vld_ff || !rsp_stall);
   assign slot_free = !pend_vld_ff || move;

   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      out_vld_in  = out_vld_ff;
      out_in      = out_ff;
      if (move) begin
         out_vld_in  = 1'b1;
         out_in      = pend_ff;
         pend_vld_in = 1'b0;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
      if (res_load) begin
         pend_vld_in = 1'b1;
         pend_in     = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         pend_vld_ff <= pend_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// File: hdl/text_mode_terminal.sv
// Top level of the text-mode character terminal.
// Depends on tmt_pkg, tmt_csr, tmt_seq, tmt_ram and tmt_rsp.
//
// A COLUMNS x ROWS character terminal whose screen lives in one synchronous RAM.
// Put-character, locate and unused-mode transactions leave the sequencer idle, so
// they can follow back to back while the result slot has room; a put-character
// that clears or scrolls starts a sweep, and a read waits in its own state for
// the registered RAM read port. A clear blanks every cell, and a scroll copies
// COLUMNS*(ROWS-1) cells at one a cycle, drains the last copy and then blanks the
// bottom row; req_stall stays high during either sweep. After reset the same
// blanking pass runs over all COLUMNS*ROWS cells (768 at the default size)
// before the first transaction is taken; configuration writes are taken at any
// time. Each result leaves through a pending slot and an output register, so a
// new transaction is taken while a result waits at the output.
module text_mode_terminal #(
   parameter int COLUMNS = 32,
   parameter int ROWS    = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [tmt_pkg::MODE_W-1:0]   req_mode,
   input  logic [tmt_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tmt_pkg::COL_W-1:0]    req_col,
   input  logic [tmt_pkg::ROW_W-1:0]    req_row,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [tmt_pkg::COL_W-1:0]    rsp_cursor_col,
   output logic [tmt_pkg::ROW_W-1:0]    rsp_cursor_row,
   output logic                         rsp_reverse_on,
   output logic                         rsp_wrote_cell,
   output logic [tmt_pkg::ADDR_W-1:0]   rsp_cell_addr,
   output logic [tmt_pkg::CHAR_W-1:0]   rsp_cell_value,
   output logic                         rsp_scrolled,
   output logic                         rsp_cleared,
   output logic [tmt_pkg::CHAR_W-1:0]   rsp_read_value,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [tmt_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tmt_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tmt_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   tmt_pkg::cfg_type            cfg;
   tmt_pkg::rsp_type            res;
   tmt_pkg::rsp_type            rsp_data;
   logic                        res_load;
   logic                        slot_free;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [AW-1:0]               mem_raddr;
   logic [tmt_pkg::CHAR_W-1:0]  mem_wdata;
   logic [tmt_pkg::CHAR_W-1:0]  mem_rdata;

   tmt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   tmt_seq #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_mode      (req_mode),
      .req_char_code (req_char_code),
      .req_col       (req_col),
      .req_row       (req_row),
      .req_stall     (req_stall),
      .slot_free     (slot_free),
      .res_load      (res_load),
      .res           (res),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_wdata     (mem_wdata),
      .mem_raddr     (mem_raddr),
      .mem_rdata     (mem_rdata)
   );

   tmt_ram #(
      .WIDTH (tmt_pkg::CHAR_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   tmt_rsp u_rsp (
      .clock     (clock),
      .reset     (reset),
      .res_load  (res_load),
      .res       (res),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_cursor_col = rsp_data.cursor_col;
   assign rsp_cursor_row = rsp_data.cursor_row;
   assign rsp_reverse_on = rsp_data.reverse_on;
   assign rsp_wrote_cell = rsp_data.wrote_cell;
   assign rsp_cell_addr  = rsp_data.cell_addr;
   assign rsp_cell_value = rsp_data.cell_value;
   assign rsp_scrolled   = rsp_data.scrolled;
   assign rsp_cleared    = rsp_data.cleared;
   assign rsp_read_value = rsp_data.read_value;

endmodule
